>>> design/bfsm_pkg.sv
// ----------------------------------------------------------------------------
// Bloom filter package
// Shared constants, operation codes and sequencer states for the two-probe
// Bloom filter with a splitmix64 key hash.
// ----------------------------------------------------------------------------
package bfsm_pkg;

  // Default size of the filter in bits (a power of two, 64 or more).
  localparam int unsigned FILTER_BITS_DEFAULT = 4096;

  // Width of one store word in bits.
  localparam int unsigned WORD_BITS = 64;

  // Operation codes carried with each request.
  localparam logic [1:0] OP_QUERY  = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // splitmix64 constants.
  localparam logic [63:0] HASH_GOLDEN = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] HASH_MUL1   = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] HASH_MUL2   = 64'h94d049bb133111eb;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_XSHIFT,
    ST_MUL,
    ST_READ1,
    ST_UPDATE1,
    ST_READ2,
    ST_UPDATE2
  } state_t;

endpackage

>>> design/bfsm_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
module bfsm_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/bloom_filter_splitmix_two_probe.sv
// ----------------------------------------------------------------------------
// Two-probe Bloom filter with splitmix64 hashing
// Query, insert and clear of a bit store held in one word-wide RAM.
// ----------------------------------------------------------------------------
// The block takes one request at a time. A query or insert holds in_ready low
// after it is accepted, until it is done: 3 xor-shift steps, two 64-bit
// multiplies on one shared 32x32 multiplier, then a read and an update of the
// RAM word for each probe. A query returns one hit result through an output
// register, so the next request can be taken while it waits; a query that
// reaches its last cycle while an earlier result is still waiting stays there
// until that result is taken. An insert and an unused operation code return
// nothing. A clear writes zero to every RAM word, one word a cycle. The same
// clearing pass runs right after reset, and in_ready rises once it is done.
module bloom_filter_splitmix_two_probe #(
  parameter int unsigned FILTER_BITS = bfsm_pkg::FILTER_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  operation,
  input  logic [31:0] key,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        hit
);

  localparam int unsigned BIT_AW     = $clog2(FILTER_BITS);
  localparam int unsigned STORE_WORDS = FILTER_BITS / bfsm_pkg::WORD_BITS;
  localparam int unsigned WORD_AW    = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;

  bfsm_pkg::state_t state, state_next;

  logic [63:0]        v;
  logic [63:0]        acc;
  logic [63:0]        prod;
  logic [1:0]         step;
  logic [1:0]         phase;
  logic               insert_op;
  logic [BIT_AW-1:0]  probe1;
  logic [BIT_AW-1:0]  probe2;
  logic               hit1;
  logic [WORD_AW-1:0] clr_addr;

  logic [63:0]        xs;
  logic [63:0]        mul_const;
  logic [31:0]        mul_a;
  logic [31:0]        mul_b;
  logic [63:0]        mul_full;
  logic [WORD_AW-1:0] word1;
  logic [WORD_AW-1:0] word2;
  logic [63:0]        mask1;
  logic [63:0]        mask2;
  logic               out_free;
  logic               clr_last;

  logic               ram_we;
  logic [WORD_AW-1:0] ram_waddr;
  logic [63:0]        ram_wdata;
  logic [WORD_AW-1:0] ram_raddr;
  logic [63:0]        ram_rdata;

  // Bit store.
  bfsm_ram #(
    .WIDTH (bfsm_pkg::WORD_BITS),
    .DEPTH (STORE_WORDS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Xor-shift step; the shift amount depends on which mixing round is running.
  always_comb begin
    case (step)
      2'd0:    xs = v ^ (v >> 30);
      2'd1:    xs = v ^ (v >> 27);
      default: xs = v ^ (v >> 31);
    endcase
  end

  // Shared multiplier. A 64-bit product modulo 2^64 is built from the low
  // partial product and the two cross terms, one per cycle.
  assign mul_const = step[0] ? bfsm_pkg::HASH_MUL2 : bfsm_pkg::HASH_MUL1;

  always_comb begin
    case (phase)
      2'd0: begin
        mul_a = v[31:0];
        mul_b = mul_const[31:0];
      end
      2'd1: begin
        mul_a = v[31:0];
        mul_b = mul_const[63:32];
      end
      default: begin
        mul_a = v[63:32];
        mul_b = mul_const[31:0];
      end
    endcase
  end

  assign mul_full = mul_a * mul_b;

  // Word addresses and bit masks of the two probes.
  assign word1 = WORD_AW'(probe1 >> 6);
  assign word2 = WORD_AW'(probe2 >> 6);
  assign mask1 = 64'd1 << probe1[5:0];
  assign mask2 = 64'd1 << probe2[5:0];

  assign out_free = !out_valid || out_ready;
  assign clr_last = (clr_addr == WORD_AW'(STORE_WORDS - 1));

  // Next state, handshake and RAM control. The second probe's word stays
  // addressed while a query waits for the output register.
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = word1;
    ram_wdata  = ram_rdata | mask1;
    ram_raddr  = ((state == bfsm_pkg::ST_READ2) || (state == bfsm_pkg::ST_UPDATE2)) ?
                 word2 : word1;
    case (state)
      bfsm_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
        if (clr_last) begin
          state_next = bfsm_pkg::ST_IDLE;
        end
      end
      bfsm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (operation)
            bfsm_pkg::OP_QUERY:  state_next = bfsm_pkg::ST_XSHIFT;
            bfsm_pkg::OP_INSERT: state_next = bfsm_pkg::ST_XSHIFT;
            bfsm_pkg::OP_CLEAR:  state_next = bfsm_pkg::ST_CLEAR;
            default:             state_next = bfsm_pkg::ST_IDLE;
          endcase
        end
      end
      bfsm_pkg::ST_XSHIFT: begin
        state_next = (step == 2'd2) ? bfsm_pkg::ST_READ1 : bfsm_pkg::ST_MUL;
      end
      bfsm_pkg::ST_MUL: begin
        if (phase == 2'd3) begin
          state_next = bfsm_pkg::ST_XSHIFT;
        end
      end
      bfsm_pkg::ST_READ1: begin
        state_next = bfsm_pkg::ST_UPDATE1;
      end
      bfsm_pkg::ST_UPDATE1: begin
        ram_we     = insert_op;
        state_next = bfsm_pkg::ST_READ2;
      end
      bfsm_pkg::ST_READ2: begin
        state_next = bfsm_pkg::ST_UPDATE2;
      end
      bfsm_pkg::ST_UPDATE2: begin
        ram_we    = insert_op;
        ram_waddr = word2;
        ram_wdata = ram_rdata | mask2;
        if (insert_op || out_free) begin
          state_next = bfsm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bfsm_pkg::ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bfsm_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Control counters and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr  <= '0;
      step      <= 2'd0;
      phase     <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if ((state == bfsm_pkg::ST_UPDATE2) && !insert_op && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        bfsm_pkg::ST_CLEAR: begin
          clr_addr <= clr_addr + WORD_AW'(1);
        end
        bfsm_pkg::ST_IDLE: begin
          clr_addr <= '0;
          step     <= 2'd0;
          phase    <= 2'd0;
        end
        bfsm_pkg::ST_XSHIFT: begin
          phase <= 2'd0;
        end
        bfsm_pkg::ST_MUL: begin
          phase <= phase + 2'd1;
          if (phase == 2'd3) begin
            step <= step + 2'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Hash datapath and probe results.
  always_ff @(posedge clk) begin
    case (state)
      bfsm_pkg::ST_IDLE: begin
        v         <= {32'd0, key} + bfsm_pkg::HASH_GOLDEN;
        insert_op <= (operation == bfsm_pkg::OP_INSERT);
      end
      bfsm_pkg::ST_XSHIFT: begin
        v      <= xs;
        probe1 <= xs[BIT_AW-1:0];
        probe2 <= xs[32 +: BIT_AW];
      end
      bfsm_pkg::ST_MUL: begin
        prod <= mul_full;
        case (phase)
          2'd0:    acc <= acc;
          2'd1:    acc <= prod;
          2'd2:    acc <= acc + {prod[31:0], 32'd0};
          default: v   <= acc + {prod[31:0], 32'd0};
        endcase
      end
      bfsm_pkg::ST_UPDATE1: begin
        hit1 <= ram_rdata[probe1[5:0]];
      end
      bfsm_pkg::ST_UPDATE2: begin
        if (!insert_op && out_free) begin
          hit <= hit1 & ram_rdata[probe2[5:0]];
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// Testbench for the two-probe Bloom filter
// Drives query, insert, clear and unused-code requests through the valid/ready
// input, predicts each hit result with a shadow copy of the bit store and a
// local splitmix64 hash, and checks every result in order. Both sides idle at
// random, and the run includes a long output stall and a full drain pause.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned FILTER_BITS  = bfsm_pkg::FILTER_BITS_DEFAULT;
  localparam int unsigned STORE_WORDS  = FILTER_BITS / bfsm_pkg::WORD_BITS;
  localparam logic [1:0]  OP_UNUSED    = 2'd3;
  localparam int          RANDOM_ITEMS = 1625;
  localparam int          SEGMENT_LEN  = 150;
  localparam int          HOLD_AT      = 300;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          PAUSE_AT     = 900;
  localparam int          DRAIN_LIMIT  = 2000;
  localparam int          TAIL_CYCLES  = 100;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] k;
    bit          typed;
    bit          typed_hit;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  operation = bfsm_pkg::OP_QUERY;
  logic [31:0] key = 32'h0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        hit;

  // Shadow copy of the filter and the hit results still owed by the block.
  logic [63:0] shadow_words [STORE_WORDS];
  bit          expected_hits [$];
  logic [31:0] inserted_keys [$];
  stim_row_t   directed_rows [$];

  bit no_idle = 1'b0;
  bit hold_armed = 1'b0;
  int mismatch_count = 0;
  int n_query = 0, n_insert = 0, n_clear = 0, n_unused = 0;
  int n_results = 0, n_hits = 0;

  bloom_filter_splitmix_two_probe #(
    .FILTER_BITS(FILTER_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .operation(operation),
    .key(key),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .hit(hit)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Generous overall limit; a correct run finishes far sooner.
  initial begin
    #10_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

  // splitmix64 finalizer over the zero-extended key, all math modulo 2^64.
  function automatic logic [63:0] splitmix_hash(input logic [31:0] k);
    logic [63:0] v;
    v = {32'h0, k} + bfsm_pkg::HASH_GOLDEN;
    v = (v ^ (v >> 30)) * bfsm_pkg::HASH_MUL1;
    v = (v ^ (v >> 27)) * bfsm_pkg::HASH_MUL2;
    return v ^ (v >> 31);
  endfunction

  function automatic int unsigned probe_index(input logic [63:0] h);
    return int'(h % 64'(FILTER_BITS));
  endfunction

  // Appends one row to the directed table.
  task automatic add_row(input logic [1:0] op, input logic [31:0] k,
                         input bit typed, input bit typed_hit);
    stim_row_t row;
    row.op = op;
    row.k = k;
    row.typed = typed;
    row.typed_hit = typed_hit;
    directed_rows.insert(directed_rows.size(), row);
  endtask

  // Records one owed hit result at the back of the queue.
  task automatic queue_hit(input bit want);
    expected_hits.insert(expected_hits.size(), want);
  endtask

  // Applies one request to the shadow store and returns the hit it owes.
  task automatic filter_apply(input logic [1:0] op, input logic [31:0] k,
                              output bit produces, output bit hit_out);
    logic [63:0] h;
    int unsigned p1, p2;
    h = splitmix_hash(k);
    p1 = probe_index(h);
    p2 = probe_index(h >> 32);
    produces = 1'b0;
    hit_out = 1'b0;
    case (op)
      bfsm_pkg::OP_CLEAR: begin
        for (int w = 0; w < STORE_WORDS; w++) shadow_words[w] = '0;
      end
      bfsm_pkg::OP_INSERT: begin
        shadow_words[p1 / bfsm_pkg::WORD_BITS][p1 % bfsm_pkg::WORD_BITS] = 1'b1;
        shadow_words[p2 / bfsm_pkg::WORD_BITS][p2 % bfsm_pkg::WORD_BITS] = 1'b1;
      end
      bfsm_pkg::OP_QUERY: begin
        produces = 1'b1;
        hit_out = shadow_words[p1 / bfsm_pkg::WORD_BITS][p1 % bfsm_pkg::WORD_BITS] &&
                  shadow_words[p2 / bfsm_pkg::WORD_BITS][p2 % bfsm_pkg::WORD_BITS];
      end
      default: ;
    endcase
  endtask

  task automatic report_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("tb_top: ERROR at %0t: %s", $realtime, msg);
  endtask

  function automatic int idle_cycles();
    return no_idle ? 0 : $urandom_range(0, 9);
  endfunction

  // Offers one request and records the expected hit once it is accepted.
  task automatic send_request(input logic [1:0] op, input logic [31:0] k,
                              input bit typed, input bit typed_hit);
    int gap;
    bit produces, predicted;
    gap = idle_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    key <= k;
    do @(posedge clk); while (in_ready !== 1'b1);
    filter_apply(op, k, produces, predicted);
    if (produces) queue_hit(typed ? typed_hit : predicted);
    case (op)
      bfsm_pkg::OP_QUERY:  n_query++;
      bfsm_pkg::OP_INSERT: n_insert++;
      bfsm_pkg::OP_CLEAR:  n_clear++;
      default:             n_unused++;
    endcase
  endtask

  // Stops offering requests until every owed result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_hits.size() != 0);
  endtask

  // Result side: random stalls, one long hold-off, in-order checking.
  initial begin
    int gap;
    bit want;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_armed) begin
        hold_armed = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      gap = idle_cycles();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      n_results++;
      if (hit === 1'b1) n_hits++;
      if (expected_hits.size() == 0) begin
        report_error($sformatf("result with nothing expected, hit=%b", hit));
      end else begin
        want = expected_hits.pop_front();
        if (hit !== want)
          report_error($sformatf("hit mismatch: expected %b, got %b", want, hit));
      end
    end
  end

  // Request side: reset, directed table, random mix, drain and verdict.
  initial begin
    logic [63:0] h, h0;
    logic [31:0] same_probe_key, half_key, k;
    logic [1:0]  op;
    int unsigned a1, a2, b1, b2;
    int          counted, next_segment, insert_weight, r, drain;

    for (int w = 0; w < STORE_WORDS; w++) shadow_words[w] = '0;

    // A key whose two probes land on one bit.
    same_probe_key = 32'h0;
    for (int unsigned c = 1; c < 32'h0100_0000; c++) begin
      h = splitmix_hash(c);
      if (probe_index(h) == probe_index(h >> 32)) begin
        same_probe_key = c;
        break;
      end
    end

    // A key that shares exactly one probed bit with key zero.
    h0 = splitmix_hash(32'h0);
    a1 = probe_index(h0);
    a2 = probe_index(h0 >> 32);
    half_key = 32'h1;
    for (int unsigned c = 1; c < 32'h0100_0000; c++) begin
      h = splitmix_hash(c);
      b1 = probe_index(h);
      b2 = probe_index(h >> 32);
      if (((b1 == a1) || (b1 == a2)) != ((b2 == a1) || (b2 == a2))) begin
        half_key = c;
        break;
      end
    end

    // Directed table: typed expectations where the answer is obvious.
    add_row(bfsm_pkg::OP_QUERY,  32'h0000_0000, 1'b1, 1'b0);
    add_row(bfsm_pkg::OP_QUERY,  32'hFFFF_FFFF, 1'b1, 1'b0);
    add_row(bfsm_pkg::OP_INSERT, 32'h0000_0000, 1'b0, 1'b0);
    add_row(bfsm_pkg::OP_QUERY,  32'h0000_0000, 1'b1, 1'b1);
    add_row(bfsm_pkg::OP_QUERY,  half_key,      1'b1, 1'b0);
    add_row(bfsm_pkg::OP_INSERT, 32'hFFFF_FFFF, 1'b0, 1'b0);
    add_row(bfsm_pkg::OP_QUERY,  32'hFFFF_FFFF, 1'b1, 1'b1);
    add_row(bfsm_pkg::OP_QUERY,  32'h8000_0000, 1'b0, 1'b0);
    add_row(OP_UNUSED,           32'h8000_0000, 1'b0, 1'b0);
    add_row(bfsm_pkg::OP_QUERY,  32'h8000_0000, 1'b0, 1'b0);
    add_row(bfsm_pkg::OP_INSERT, 32'h8000_0000, 1'b0, 1'b0);
    add_row(bfsm_pkg::OP_QUERY,  32'h7FFF_FFFF, 1'b0, 1'b0);
    add_row(bfsm_pkg::OP_QUERY,  32'h8000_0000, 1'b1, 1'b1);
    add_row(bfsm_pkg::OP_CLEAR,  32'h0000_0000, 1'b0, 1'b0);
    add_row(bfsm_pkg::OP_QUERY,  32'h0000_0000, 1'b1, 1'b0);
    add_row(bfsm_pkg::OP_QUERY,  32'hFFFF_FFFF, 1'b1, 1'b0);
    add_row(bfsm_pkg::OP_QUERY,  same_probe_key, 1'b1, 1'b0);
    add_row(bfsm_pkg::OP_INSERT, same_probe_key, 1'b0, 1'b0);
    add_row(bfsm_pkg::OP_QUERY,  same_probe_key, 1'b1, 1'b1);
    add_row(OP_UNUSED,           32'hFFFF_FFFF, 1'b0, 1'b0);
    add_row(bfsm_pkg::OP_INSERT, 32'h5555_5555, 1'b0, 1'b0);
    add_row(bfsm_pkg::OP_QUERY,  32'hAAAA_AAAA, 1'b0, 1'b0);
    add_row(bfsm_pkg::OP_CLEAR,  32'hFFFF_FFFF, 1'b0, 1'b0);
    add_row(bfsm_pkg::OP_QUERY,  32'h5555_5555, 1'b1, 1'b0);
    add_row(bfsm_pkg::OP_QUERY,  same_probe_key, 1'b1, 1'b0);

    // Reset; the block then runs its clearing pass before taking requests.
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_request(directed_rows[i].op, directed_rows[i].k,
                   directed_rows[i].typed, directed_rows[i].typed_hit);

    // Random part in segments with varying insert density and idling.
    counted = 0;
    next_segment = 0;
    insert_weight = 80;
    while (counted < RANDOM_ITEMS) begin
      if (counted >= next_segment) begin
        next_segment += SEGMENT_LEN;
        case ($urandom_range(0, 2))
          0:       insert_weight = 40;
          1:       insert_weight = 80;
          default: insert_weight = 140;
        endcase
        no_idle = ($urandom_range(0, 3) == 0);
      end
      if (counted == HOLD_AT) hold_armed = 1'b1;
      if (counted == PAUSE_AT) begin
        wait_drained();
        counted++;
        continue;
      end

      r = $urandom_range(0, 199);
      if (r < 2)                  op = bfsm_pkg::OP_CLEAR;
      else if (r < 8)             op = OP_UNUSED;
      else if (r < 8 + insert_weight) op = bfsm_pkg::OP_INSERT;
      else                        op = bfsm_pkg::OP_QUERY;

      r = $urandom_range(0, 15);
      if (r == 0)      k = 32'h0000_0000;
      else if (r == 1) k = 32'hFFFF_FFFF;
      else if (op == bfsm_pkg::OP_QUERY && r < 9 && inserted_keys.size() > 0)
        k = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
      else             k = $urandom;

      if (op == bfsm_pkg::OP_INSERT) begin
        inserted_keys.insert(inserted_keys.size(), k);
        if (inserted_keys.size() > 64) void'(inserted_keys.pop_front());
      end else if (op == bfsm_pkg::OP_CLEAR) begin
        inserted_keys.delete();
      end

      send_request(op, k, 1'b0, 1'b0);
      if (op != OP_UNUSED) counted++;
    end

    // Drain the owed results, then let the block settle.
    in_valid <= 1'b0;
    for (drain = 0; drain < DRAIN_LIMIT && expected_hits.size() > 0; drain++)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_hits.size() > 0)
      report_error($sformatf("%0d expected results never arrived", expected_hits.size()));

    $display("tb_top: sent %0d queries, %0d inserts, %0d clears, %0d unused codes",
             n_query, n_insert, n_clear, n_unused);
    $display("tb_top: checked %0d results (%0d hits), %0d mismatches",
             n_results, n_hits, mismatch_count);
    if (mismatch_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
